/* hw/rtl/fdse_pkg.sv */
// ----------------------------------------------------------------------------
// fdse_pkg
// Types and codes shared by the state estimator modules.
// ----------------------------------------------------------------------------
package fdse_pkg;

  localparam logic [2:0] MODE_CALIBRATE = 3'd1;
  localparam logic [2:0] MODE_RUN       = 3'd2;

  typedef enum logic [1:0] {
    OP_RATE = 2'd0,
    OP_EXTRAP = 2'd1,
    OP_SQRT = 2'd2
  } op_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MX,
    ST_MY,
    ST_CX,
    ST_LEN,
    ST_LRATE,
    ST_OUT
  } state_t;

endpackage

/* hw/rtl/fdse_if.sv */
// ----------------------------------------------------------------------------
// fdse_in_if / fdse_out_if
// Valid/ready channels for sample words and published state words.
// ----------------------------------------------------------------------------
interface fdse_in_if;
  logic        valid;
  logic        ready;
  logic        cmd;
  logic        bad_sample;
  logic [31:0] coord_x;
  logic [31:0] coord_y;
  logic [31:0] time_stamp;
  modport source (output valid, cmd, bad_sample, coord_x, coord_y, time_stamp,
                  input ready);
  modport sink (input valid, cmd, bad_sample, coord_x, coord_y, time_stamp,
                output ready);
endinterface

interface fdse_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] mass_x;
  logic [31:0] mass_y;
  logic [31:0] cart_x;
  logic [30:0] string_length;
  logic [31:0] mass_vel_x;
  logic [31:0] mass_vel_y;
  logic [31:0] cart_vel_x;
  logic [31:0] length_rate;
  logic [31:0] out_stamp;
  modport source (output valid, mass_x, mass_y, cart_x, string_length, mass_vel_x,
                  mass_vel_y, cart_vel_x, length_rate, out_stamp, input ready);
  modport sink (input valid, mass_x, mass_y, cart_x, string_length, mass_vel_x,
                mass_vel_y, cart_vel_x, length_rate, out_stamp, output ready);
endinterface

/* hw/rtl/fdse_alu.sv */
// ----------------------------------------------------------------------------
// fdse_alu
// Shared iterative unit: rate division, dead-reckoning multiply, square root.
// ----------------------------------------------------------------------------
module fdse_alu import fdse_pkg::*; #(
  parameter int VW = 32,
  parameter int FB = 16
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  op_t           op,
  input  logic [VW:0]   a,      // rate: diff; extrap: pos; sqrt: dx
  input  logic [VW-1:0] b,      // rate: held; extrap: vel; sqrt: dy
  input  logic [31:0]   dt,
  output logic          done,
  output logic [VW-1:0] res
);
  localparam int AW  = 2 * VW + FB + 2;
  localparam int CW  = 8;
  localparam int IW  = $clog2(VW + 1);
  localparam logic signed [VW+1:0] VMAX = {3'b000, {(VW - 1){1'b1}}};
  localparam logic signed [VW+1:0] VMIN = -VMAX - 1;

  op_t            op_r;
  logic           busy_r;
  logic [CW-1:0]  cnt_r;
  logic           neg_r;
  logic [AW-1:0]  acc_r;     // remainder / product / radicand
  logic [AW-1:0]  q_r;       // quotient; extrap: position; sqrt: dy, then root squared
  logic [VW:0]    mag_r;     // dividend / multiplicand magnitude; sqrt: dx, then root
  logic           done_r;
  logic [VW-1:0]  res_r;

  logic [VW:0] mag_a, mag_b;
  logic [IW-1:0] div_idx;
  logic [AW-1:0] div_trial;
  logic signed [VW+1:0] sres;
  logic [AW-1:0] cap;
  logic [AW-1:0] prod_s;

  // last-step results built from the values of the final cycle
  logic [AW-1:0] qf;
  logic [VW-1:0] res_rate, res_ext, res_sqrt;
  logic [AW-1:0] accf;
  logic [VW:0] rootf;

  assign mag_a = a[VW] ? (~a + 1'b1) : a;
  assign mag_b = b[VW-1] ? (~{1'b1, b} + 1'b1) : {1'b0, b};
  assign cap = neg_r ? AW'(VMAX) + 1'b1 : AW'(VMAX);

  // next partial remainder: bring down a dividend bit, then zeros for the fraction
  assign div_idx = IW'(cnt_r - CW'(FB) - CW'(1));
  assign div_trial = (cnt_r > CW'(FB)) ? {acc_r[AW-2:0], mag_r[div_idx]}
                                       : {acc_r[AW-2:0], 1'b0};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        op_r   <= op;
        case (op)
          OP_RATE: begin
            neg_r <= a[VW];
            mag_r <= mag_a;
            acc_r <= '0;
            q_r   <= '0;
            cnt_r <= CW'(VW + 1 + FB);
            if (dt == 32'd0) begin
              busy_r <= 1'b0;
              done_r <= 1'b1;
              res_r  <= b;
            end
          end
          OP_EXTRAP: begin
            neg_r <= b[VW-1];
            mag_r <= mag_b;
            acc_r <= '0;
            q_r   <= AW'(a);
            cnt_r <= CW'(32);
          end
          default: begin
            // radicand dx^2 + dy^2 built with the adder over cycles
            neg_r <= 1'b0;
            if (mag_a > (VW + 1)'(VMAX) || mag_b > (VW + 1)'(VMAX)) begin
              busy_r <= 1'b0;
              done_r <= 1'b1;
              res_r  <= VMAX[VW-1:0];
            end
            mag_r <= mag_a;
            q_r   <= AW'(mag_b);
            acc_r <= '0;
            cnt_r <= CW'(2 * VW + VW);
          end
        endcase
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        case (op_r)
          OP_RATE: begin
            // restoring division of mag * 2^FB by dt, one bit a cycle
            if (div_trial >= AW'(dt)) begin
              acc_r <= div_trial - AW'(dt);
              q_r   <= {q_r[AW-2:0], 1'b1};
            end else begin
              acc_r <= div_trial;
              q_r   <= {q_r[AW-2:0], 1'b0};
            end
            if (cnt_r == CW'(1)) begin
              busy_r <= 1'b0;
            end
          end
          OP_EXTRAP: begin
            // shift-add multiply |vel| * dt, one bit of dt a cycle
            acc_r <= dt[5'(cnt_r - 1'b1)] ? {acc_r[AW-2:0], 1'b0} + AW'(mag_r)
                                          : {acc_r[AW-2:0], 1'b0};
            if (cnt_r == CW'(1)) begin
              busy_r <= 1'b0;
            end
          end
          default: begin
            if (cnt_r > CW'(VW)) begin
              // square: dx then dy, one bit a cycle
              if (cnt_r > CW'(2 * VW)) begin
                if (mag_r[IW'(cnt_r - CW'(2 * VW) - 1'b1)])
                  acc_r <= acc_r + (AW'(mag_r) << (cnt_r - CW'(2 * VW) - 1'b1));
              end else begin
                if (q_r[IW'(cnt_r - CW'(VW) - 1'b1)])
                  acc_r <= acc_r + (q_r << (cnt_r - CW'(VW) - 1'b1));
              end
              if (cnt_r == CW'(VW + 1)) begin
                q_r   <= '0;
                mag_r <= '0;
              end
            end else begin
              // root bit cnt-1: keep it if (c|bit)^2 <= s
              if (q_r + (AW'(mag_r) << cnt_r) + (AW'(1) << (2 * (cnt_r - 1'b1)))
                  <= acc_r) begin
                mag_r <= mag_r | ((VW + 1)'(1) << (cnt_r - 1'b1));
                q_r   <= q_r + (AW'(mag_r) << cnt_r) + (AW'(1) << (2 * (cnt_r - 1'b1)));
              end
              if (cnt_r == CW'(1)) begin
                busy_r <= 1'b0;
              end
            end
          end
        endcase
        if (cnt_r == CW'(1)) begin
          done_r <= 1'b1;
          case (op_r)
            OP_RATE: res_r <= res_rate;
            OP_EXTRAP: res_r <= res_ext;
            default: res_r <= res_sqrt;
          endcase
        end
      end
    end
  end

  always_comb begin
    qf = {q_r[AW-2:0], (div_trial >= AW'(dt))};
    if (qf > cap) qf = cap;
    sres = neg_r ? -$signed((VW + 2)'(qf)) : $signed((VW + 2)'(qf));
    res_rate = sres[VW-1:0];
    accf = dt[0] ? {acc_r[AW-2:0], 1'b0} + AW'(mag_r) : {acc_r[AW-2:0], 1'b0};
    prod_s = accf >> FB;
    if (prod_s > (AW'(1) << VW)) prod_s = AW'(1) << VW;
    sres = $signed({{2{q_r[VW-1]}}, q_r[VW-1:0]})
           + (neg_r ? -$signed({1'b0, prod_s[VW:0]}) : $signed({1'b0, prod_s[VW:0]}));
    if (sres > VMAX) sres = VMAX;
    if (sres < VMIN) sres = VMIN;
    res_ext = sres[VW-1:0];
    rootf = mag_r;
    if (q_r + (AW'(mag_r) << 1) + AW'(1) <= acc_r) rootf = mag_r | (VW + 1)'(1);
    res_sqrt = (rootf > (VW + 1)'(VMAX)) ? VMAX[VW-1:0] : rootf[VW-1:0];
  end

  assign done = done_r;
  assign res  = res_r;
endmodule

/* hw/rtl/finite_difference_state_estimator.sv */
// ----------------------------------------------------------------------------
// finite_difference_state_estimator
// Mass and cart position/velocity estimator with dead reckoning.
// ----------------------------------------------------------------------------
// One sample word is taken at a time; ready stays low until the word is fully
// processed. Every rate, extrapolation and square root runs on the single
// shared unit in fdse_alu, one bit a cycle. A rate with no elapsed time hands
// back the held value, and a string length with an operand out of range the
// saturated maximum, without the bit steps. A good mass word takes two rates,
// a bad one two extrapolations; a good cart word takes a rate, a string length
// and a length rate and then hands over the published word, a bad cart word an
// extrapolation and a string length before the hand-over. The published word
// sits in an output register, so the next sample is taken while it waits; a
// later cart word only stalls in the hand-over state if that register is
// still full.
module finite_difference_state_estimator import fdse_pkg::*; #(
  parameter int VALUE_WIDTH = 32,
  parameter int FRAC_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  fdse_in_if.sink     in_ch,
  fdse_out_if.source  out_ch,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [1:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  localparam int VW = VALUE_WIDTH;
  localparam int PW = 8 * 32 + 31;

  logic [2:0] run_mode_r;
  state_t state_r, state_nxt;

  logic [VW-1:0] mpx_r, mpy_r, mvx_r, mvy_r, cp_r, cv_r, len_r, lr_r;
  logic [31:0] lmt_r, lct_r, ts_r, dt_r;
  logic bad_r, wait_r;
  logic [VW-1:0] x_r, y_r;

  logic start;
  op_t op;
  logic [VW:0] a_op;
  logic [VW-1:0] b_op, alu_res;
  logic alu_done;

  logic [PW-1:0] pub_r;
  logic out_valid_r;
  logic load_pub;

  // take writes at the access phase; pready is always high
  assign cfg_pready = 1'b1;
  assign cfg_prdata = {29'd0, run_mode_r};
  always_ff @(posedge clk) begin
    if (!rst_n) run_mode_r <= '0;
    else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_paddr == 2'd0)
      run_mode_r <= cfg_pwdata[2:0];
  end

  // saturate inputs on entry
  function automatic logic [VW-1:0] sat_in(input logic [31:0] v);
    logic signed [63:0] s;
    logic signed [63:0] mx;
    begin
      s  = 64'($signed(v));
      mx = (64'sd1 <<< (VW - 1)) - 64'sd1;
      if (s > mx) s = mx;
      if (s < -mx - 64'sd1) s = -mx - 64'sd1;
      sat_in = s[VW-1:0];
    end
  endfunction

  assign in_ch.ready = (state_r == ST_IDLE);
  logic acc;
  assign acc = in_ch.valid && in_ch.ready;

  // load the published word once the output register is free or draining
  assign load_pub = (state_r == ST_OUT) && (!out_valid_r || out_ch.ready);

  fdse_alu #(.VW(VW), .FB(FRAC_BITS)) u_alu (
    .clk, .rst_n, .start, .op, .a(a_op), .b(b_op), .dt(dt_r),
    .done(alu_done), .res(alu_res)
  );

  always_comb begin
    state_nxt = state_r;
    start = 1'b0;
    op = OP_RATE;
    a_op = '0;
    b_op = '0;
    case (state_r)
      ST_IDLE: if (acc) begin
        if (!in_ch.cmd) state_nxt = ST_MX;
        else if (run_mode_r == MODE_CALIBRATE || run_mode_r == MODE_RUN)
          state_nxt = ST_CX;
      end
      ST_MX, ST_MY: begin
        start = !wait_r;
        op = bad_r ? OP_EXTRAP : OP_RATE;
        if (state_r == ST_MX) begin
          a_op = bad_r ? {mpx_r[VW-1], mpx_r} : {x_r[VW-1], x_r} - {mpx_r[VW-1], mpx_r};
          b_op = mvx_r;
        end else begin
          a_op = bad_r ? {mpy_r[VW-1], mpy_r} : {y_r[VW-1], y_r} - {mpy_r[VW-1], mpy_r};
          b_op = mvy_r;
        end
        if (alu_done) state_nxt = (state_r == ST_MX) ? ST_MY : ST_IDLE;
      end
      ST_CX: begin
        start = !wait_r;
        op = bad_r ? OP_EXTRAP : OP_RATE;
        a_op = bad_r ? {cp_r[VW-1], cp_r} : {x_r[VW-1], x_r} - {cp_r[VW-1], cp_r};
        b_op = cv_r;
        if (alu_done) state_nxt = ST_LEN;
      end
      ST_LEN: begin
        start = !wait_r;
        op = OP_SQRT;
        a_op = {cp_r[VW-1], cp_r} - {mpx_r[VW-1], mpx_r};
        b_op = mpy_r;
        if (alu_done) state_nxt = bad_r ? ST_OUT : ST_LRATE;
      end
      ST_LRATE: begin
        start = !wait_r;
        op = OP_RATE;
        a_op = {1'b0, y_r} - {1'b0, len_r};
        b_op = lr_r;
        if (alu_done) state_nxt = ST_OUT;
      end
      ST_OUT: if (!out_valid_r || out_ch.ready) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      wait_r  <= 1'b0;
      {mpx_r, mpy_r, mvx_r, mvy_r, cp_r, cv_r, len_r, lr_r} <= '0;
      lmt_r <= '0;
      lct_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (start) wait_r <= 1'b1;
      if (alu_done) wait_r <= 1'b0;
      if (acc) begin
        bad_r <= in_ch.bad_sample;
        x_r   <= sat_in(in_ch.coord_x);
        y_r   <= sat_in(in_ch.coord_y);
        ts_r  <= in_ch.time_stamp;
        if (!in_ch.cmd) begin
          dt_r  <= in_ch.time_stamp - lmt_r;
          lmt_r <= in_ch.time_stamp;
        end else if (run_mode_r == MODE_CALIBRATE || run_mode_r == MODE_RUN) begin
          dt_r  <= in_ch.time_stamp - lct_r;
          lct_r <= in_ch.time_stamp;
        end
      end
      if (alu_done) begin
        case (state_r)
          ST_MX: if (bad_r) mpx_r <= alu_res; else begin mvx_r <= alu_res; mpx_r <= x_r; end
          ST_MY: if (bad_r) mpy_r <= alu_res; else begin mvy_r <= alu_res; mpy_r <= y_r; end
          ST_CX: if (bad_r) cp_r <= alu_res; else begin cv_r <= alu_res; cp_r <= x_r; end
          ST_LEN: begin
            // park the new length in y_r for the rate step
            if (bad_r) len_r <= alu_res;
            else y_r <= alu_res;
          end
          ST_LRATE: begin
            lr_r  <= alu_res;
            len_r <= y_r;
          end
          default: ;
        endcase
      end
      // hold the published word until taken
      if (load_pub) begin
        out_valid_r <= 1'b1;
        pub_r <= {32'($signed(mpx_r)), 32'($signed(mpy_r)), 32'($signed(cp_r)),
                  31'(len_r), 32'($signed(mvx_r)), 32'($signed(mvy_r)),
                  32'($signed(cv_r)), 32'($signed(lr_r)), ts_r};
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_ch.valid = out_valid_r;
  assign {out_ch.mass_x, out_ch.mass_y, out_ch.cart_x, out_ch.string_length,
          out_ch.mass_vel_x, out_ch.mass_vel_y, out_ch.cart_vel_x,
          out_ch.length_rate, out_ch.out_stamp} = pub_r;

`ifndef SYNTHESIS
  a_no_take_busy: assert property (@(posedge clk) disable iff (!rst_n)
    state_r != ST_IDLE |-> !in_ch.ready) else $error("ready while busy");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.ready |=> out_ch.valid) else $error("word dropped");
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.ready |=> $stable(pub_r)) else $error("word changed");
  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> state_r != ST_IDLE && state_r != ST_OUT) else $error("bad start");
`endif
endmodule
